// ===== hdl/dssm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared memory package
// Shared constants, command and status codes, and control structs.
// ----------------------------------------------------------------------------
package dssm_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WORD_BITS_DEF   = 32;

    localparam int CNT_W  = 9;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic [1:0] TOP_ZERO = 2'd0;
    localparam logic [1:0] TOP_ONES = 2'd1;
    localparam logic [1:0] TOP_MEM  = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic [1:0]       top_sel;
        logic [1:0]       status;
        logic [CNT_W-1:0] count_a;
        logic [CNT_W-1:0] count_b;
    } t_res;

endpackage

// ===== hdl/dual_stack_shared_memory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared memory
// Two stacks in one RAM: stack A grows up from 0, stack B down from capacity.
// ----------------------------------------------------------------------------
// On accept the depths update and the RAM access issues; the execute state
// then loads the result register from the RAM read port once the output is
// free. A word is accepted whenever the control sequencer is idle, even
// while the previous result still waits on the master side. A capacity
// write empties both stacks; the RAM needs no clearing after reset.
module dual_stack_shared_memory #(
    parameter int MAX_ENTRIES = dssm_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_BITS   = dssm_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [dssm_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,  // push_value
    input  logic [2:0]                 s_axis_tuser,  // cmd[1:0], stack_sel
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // top_data[31:0], status, count_a, count_b, empty_a, empty_b, zero pad
    output logic [55:0]                m_axis_tdata
);
    import dssm_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic        r_state, n_state;
    logic        r_out_valid;
    logic [55:0] r_out_data, n_out_data;

    logic                  w_go;
    logic                  w_cfg_we;
    logic                  w_load;
    t_mem_ctl              w_mem_ctl;
    logic [AW-1:0]         w_addr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [WORD_BITS-1:0]  w_rdata;
    t_res                  w_res;
    logic [WORD_BITS+DATA_W-1:0] w_rext;
    logic [DATA_W-1:0]     w_top;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_go          = s_axis_tvalid && s_axis_tready;
    assign w_cfg_we      = i_cfg_valid;
    assign w_load        = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);

    dssm_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_BITS   (WORD_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_cap    (i_cfg_data),
        .i_go         (w_go),
        .i_cmd        (s_axis_tuser[1:0]),
        .i_stack_sel  (s_axis_tuser[2]),
        .i_push_value (s_axis_tdata),
        .o_mem_ctl    (w_mem_ctl),
        .o_addr       (w_addr),
        .o_wdata      (w_wdata),
        .o_res        (w_res)
    );

    dssm_mem #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_rext = {{DATA_W{w_rdata[WORD_BITS-1]}}, w_rdata};

    always_comb begin
        case (w_res.top_sel)
            TOP_MEM:  w_top = w_rext[DATA_W-1:0];
            TOP_ONES: w_top = '1;
            default:  w_top = '0;
        endcase
        n_out_data = {2'b00, (w_res.count_b == '0), (w_res.count_a == '0),
                      w_res.count_b, w_res.count_a, w_res.status, w_top};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_go) n_state = ST_EXEC;
            ST_EXEC: if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("result not delivered after execute");

    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> (r_state == ST_EXEC) && !s_axis_tready)
        else $error("second word accepted while one is in flight");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid && $stable(m_axis_tdata))
        else $error("pending result overwritten");

endmodule

// ===== hdl/dssm_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared memory array
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dssm_mem #(
    parameter int DEPTH = dssm_pkg::MAX_ENTRIES_DEF,
    parameter int WIDTH = dssm_pkg::WORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  dssm_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    import dssm_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dssm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual stack shared memory control
// Holds capacity and both stack depths, decodes each word into at most one
// memory access and registers the result fields.
// ----------------------------------------------------------------------------
module dssm_ctrl #(
    parameter int MAX_ENTRIES = dssm_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_BITS   = dssm_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dssm_pkg::CNT_W-1:0]     i_cfg_cap,
    input  logic                           i_go,
    input  logic [1:0]                     i_cmd,
    input  logic                           i_stack_sel,
    input  logic [dssm_pkg::DATA_W-1:0]    i_push_value,
    output dssm_pkg::t_mem_ctl             o_mem_ctl,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_addr,
    output logic [WORD_BITS-1:0]           o_wdata,
    output dssm_pkg::t_res                 o_res
);
    import dssm_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_depth_a, n_depth_a;
    logic [CNT_W-1:0] r_depth_b, n_depth_b;
    t_res             r_res, n_res;

    logic [CNT_W-1:0]       w_cap_use;
    logic [CNT_W:0]         w_used;
    logic                   w_full;
    logic [CNT_W-1:0]       w_depth;
    logic [CNT_W-1:0]       w_addr;
    logic [DATA_W+WORD_BITS-1:0] w_wext;

    always_comb begin
        if (r_cap == '0) begin
            w_cap_use = CNT_W'(1);
        end else if (int'(r_cap) > MAX_ENTRIES) begin
            w_cap_use = CNT_W'(MAX_ENTRIES);
        end else begin
            w_cap_use = r_cap;
        end
    end

    assign w_used  = {1'b0, r_depth_a} + {1'b0, r_depth_b};
    assign w_full  = w_used >= {1'b0, w_cap_use};
    assign w_depth = i_stack_sel ? r_depth_b : r_depth_a;
    assign w_wext  = {{WORD_BITS{1'b0}}, i_push_value};

    always_comb begin
        n_depth_a       = r_depth_a;
        n_depth_b       = r_depth_b;
        o_mem_ctl.wr_en = 1'b0;
        o_mem_ctl.rd_en = 1'b0;
        w_addr          = '0;
        n_res.top_sel   = TOP_ZERO;
        n_res.status    = ST_OK;
        case (i_cmd)
            CMD_PUSH: begin
                if (w_full) begin
                    n_res.status = ST_OVERFLOW;
                end else if (i_stack_sel) begin
                    w_addr          = w_cap_use - CNT_W'(1) - r_depth_b;
                    o_mem_ctl.wr_en = i_go;
                    n_depth_b       = r_depth_b + CNT_W'(1);
                end else begin
                    w_addr          = r_depth_a;
                    o_mem_ctl.wr_en = i_go;
                    n_depth_a       = r_depth_a + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (w_depth == '0) begin
                    n_res.status = ST_UNDERFLOW;
                end else if (i_stack_sel) begin
                    n_depth_b = r_depth_b - CNT_W'(1);
                end else begin
                    n_depth_a = r_depth_a - CNT_W'(1);
                end
            end
            CMD_PEEK: begin
                if (w_depth == '0) begin
                    n_res.status  = ST_UNDERFLOW;
                    n_res.top_sel = TOP_ONES;
                end else begin
                    w_addr          = i_stack_sel ? (w_cap_use - r_depth_b)
                                                  : (r_depth_a - CNT_W'(1));
                    o_mem_ctl.rd_en = i_go;
                    n_res.top_sel   = TOP_MEM;
                end
            end
            default: begin
            end
        endcase
        n_res.count_a = n_depth_a;
        n_res.count_b = n_depth_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_depth_a <= '0;
            r_depth_b <= '0;
        end else if (i_cfg_we) begin
            r_cap     <= i_cfg_cap;
            r_depth_a <= '0;
            r_depth_b <= '0;
        end else if (i_go) begin
            r_depth_a <= n_depth_a;
            r_depth_b <= n_depth_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_res <= n_res;
        end
    end

    assign o_addr  = AW'(w_addr);
    assign o_wdata = w_wext[WORD_BITS-1:0];
    assign o_res   = r_res;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= {1'b0, w_cap_use})
        else $error("stack depths exceed capacity");

    a_access_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.wr_en && o_mem_ctl.rd_en))
        else $error("read and write issued together");

    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_ctl.wr_en || o_mem_ctl.rd_en) |-> (w_addr < w_cap_use))
        else $error("memory access beyond capacity");

endmodule
